// ===== src/assert_macros.svh =====
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define TMA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define TMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tma_pkg.sv =====
package tma_pkg;

  localparam int VAL_W = 64;
  localparam int CNT_W = 17;
  localparam int CMD_W = 3;
  localparam int ST_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam longint unsigned MAX_CAPACITY_DEF = 64'd65536;

  // job queue depth, power of two
  localparam int JOB_DEPTH = 4;

  localparam int DIV_STEPS = VAL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MEAN  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUM   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_TOO_FEW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_IDX   = 2'd1;

  localparam logic [1:0]       WIDTH_RESET = 2'd0;
  localparam logic [CNT_W-1:0] CAP_RESET   = 17'd16;

  typedef struct packed {
    logic             is_div;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] divisor;
    logic [ST_W-1:0]  status;
  } job_t;

  function automatic logic [VAL_W-1:0] width_mask(input logic [1:0] code);
    logic [VAL_W-1:0] m;
    case (code)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

// ===== src/tma_fifo.sv =====
module tma_fifo #(
  parameter type T = tma_pkg::job_t,
  parameter int DEPTH = tma_pkg::JOB_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  T     wr_data,
  output logic full,
  input  logic rd_en,
  output T     rd_data,
  output logic valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/tma_front.sv =====
module tma_front #(
  parameter longint unsigned MAX_CAPACITY = tma_pkg::MAX_CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tma_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            accept,
  input  logic [tma_pkg::CMD_W-1:0]       command,
  input  logic [tma_pkg::VAL_W-1:0]       sample,
  output logic                            job_push,
  output tma_pkg::job_t                   job
);

  localparam int CW = tma_pkg::CNT_W;
  localparam longint unsigned CNT_ALL = (64'd1 << CW) - 64'd1;
  localparam logic [CW-1:0] CAP_CLAMP =
    CW'((MAX_CAPACITY > CNT_ALL) ? CNT_ALL : MAX_CAPACITY);

  logic [1:0]                  width_code;
  logic [CW-1:0]               capacity;
  logic [CW-1:0]               sample_count;
  logic [tma_pkg::VAL_W-1:0]   running_sum;
  logic [tma_pkg::VAL_W-1:0]   running_min;
  logic [tma_pkg::VAL_W-1:0]   running_max;

  logic [CW-1:0]               limit;
  logic [tma_pkg::VAL_W-1:0]   masked;
  logic                        is_full;

  assign limit    = (capacity < CAP_CLAMP) ? capacity : CAP_CLAMP;
  assign masked   = sample & tma_pkg::width_mask(width_code);
  assign is_full  = (sample_count >= limit);
  assign job_push = accept;

  always_comb begin
    job = '{is_div: 1'b0, value: '0, divisor: '0, status: tma_pkg::ST_OK};
    case (command)
      tma_pkg::CMD_ADD: begin
        if (is_full) begin
          job.status = tma_pkg::ST_FULL;
        end
      end
      tma_pkg::CMD_MEAN: begin
        if (sample_count < CW'(3)) begin
          job.status = tma_pkg::ST_TOO_FEW;
        end else begin
          job.is_div  = 1'b1;
          job.value   = running_sum - running_min - running_max;
          job.divisor = sample_count - CW'(2);
        end
      end
      tma_pkg::CMD_SUM:   job.value = running_sum;
      tma_pkg::CMD_COUNT: job.value = tma_pkg::VAL_W'(sample_count);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_code   <= tma_pkg::WIDTH_RESET;
      capacity     <= tma_pkg::CAP_RESET;
      sample_count <= '0;
      running_sum  <= '0;
      running_min  <= '1;
      running_max  <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tma_pkg::CFG_WIDTH_IDX) begin
          width_code <= cfg_data[1:0];
        end else if (cfg_index == tma_pkg::CFG_CAP_IDX) begin
          capacity <= cfg_data[CW-1:0];
        end
      end
      if (accept) begin
        if (command == tma_pkg::CMD_ADD && !is_full) begin
          sample_count <= sample_count + 1'b1;
          running_sum  <= running_sum + masked;
          if (masked < running_min) begin
            running_min <= masked;
          end
          if (masked > running_max) begin
            running_max <= masked;
          end
        end else if (command == tma_pkg::CMD_CLEAR) begin
          sample_count <= '0;
          running_sum  <= '0;
          running_min  <= '1;
          running_max  <= '0;
        end
      end
    end
  end

endmodule

// ===== src/tma_back.sv =====
module tma_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_valid,
  input  tma_pkg::job_t                  job,
  output logic                           job_pop,
  input  logic                           pop,
  output logic                           empty,
  output logic [tma_pkg::VAL_W-1:0]      value,
  output logic [tma_pkg::ST_W-1:0]       status
);

  localparam int VW = tma_pkg::VAL_W;
  localparam int CW = tma_pkg::CNT_W;

  typedef enum logic [1:0] {IDLE, DIV, DONE} state_t;

  state_t                         state;
  logic                           out_valid;
  logic                           out_free;
  logic [VW-1:0]                  quo;
  logic [CW:0]                    rem;
  logic [CW-1:0]                  dvsr;
  logic [tma_pkg::DIV_CNT_W-1:0]  cnt;
  logic [CW:0]                    trial;
  logic                           fits;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign job_pop  = (state == IDLE) && job_valid && (job.is_div || out_free);

  // restoring divide, one quotient bit per cycle
  assign trial = {rem[CW-1:0], quo[VW-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (job_valid) begin
            if (job.is_div) begin
              quo   <= job.value;
              dvsr  <= job.divisor;
              rem   <= '0;
              cnt   <= '0;
              state <= DIV;
            end else if (out_free) begin
              value     <= job.value;
              status    <= job.status;
              out_valid <= 1'b1;
            end
          end
        end
        DIV: begin
          rem <= fits ? (trial - {1'b0, dvsr}) : trial;
          quo <= {quo[VW-2:0], fits};
          cnt <= cnt + 1'b1;
          if (cnt == tma_pkg::DIV_CNT_W'(tma_pkg::DIV_STEPS - 1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            value     <= quo;
            status    <= tma_pkg::ST_OK;
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/trimmed_mean_accumulator_top.sv =====
// Add, clear, sum, count, spare and too-few beats: job queue, then output register.
// Trimmed mean: job queue, bit-serial divider (64 steps), then output register.
// One beat accepted per cycle while the job queue is not full; a mean holds the back end
// through the divide, and the 4-entry job queue absorbs beats meanwhile.
// Synchronous active-high rst: statistics cleared (min all ones), width 8 bits,
// capacity 16, both queues empty.
`include "assert_macros.svh"

module trimmed_mean_accumulator_top #(
  parameter longint unsigned MAX_CAPACITY = tma_pkg::MAX_CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tma_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [tma_pkg::CMD_W-1:0]       command,
  input  logic [tma_pkg::VAL_W-1:0]       sample,
  output logic                            empty,
  input  logic                            pop,
  output logic [tma_pkg::VAL_W-1:0]       value,
  output logic [tma_pkg::ST_W-1:0]        status
);

  logic          accept;
  logic          job_push;
  logic          job_full;
  logic          job_valid;
  logic          job_pop;
  tma_pkg::job_t job_in;
  tma_pkg::job_t job_out;

  assign full   = job_full;
  assign accept = push && !job_full;

  tma_front #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .command  (command),
    .sample   (sample),
    .job_push (job_push),
    .job      (job_in)
  );

  tma_fifo #(
    .T    (tma_pkg::job_t),
    .DEPTH(tma_pkg::JOB_DEPTH)
  ) u_jobq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_data(job_in),
    .full   (job_full),
    .rd_en  (job_pop),
    .rd_data(job_out),
    .valid  (job_valid)
  );

  tma_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job      (job_out),
    .job_pop  (job_pop),
    .pop      (pop),
    .empty    (empty),
    .value    (value),
    .status   (status)
  );

  `TMA_ASSERT(a_beat_queued, clk, rst, (push && !full) |-> (job_push && !job_full), "accepted beat not queued")
  `TMA_ASSERT(a_pop_nonempty, clk, rst, job_pop |-> job_valid, "job popped from empty queue")
  `TMA_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (empty && !job_valid), "not empty after reset")

endmodule

// ===== tb/tb_trimmed_mean_accumulator_top.sv =====
module tb_trimmed_mean_accumulator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

  localparam logic [tma_pkg::CMD_W-1:0] CMD_SPARE_LO = tma_pkg::CMD_COUNT + 3'd1;
  localparam logic [tma_pkg::CMD_W-1:0] CMD_SPARE_HI = '1;

  localparam logic [tma_pkg::CFG_IDX_W-1:0] CFG_SPARE_A_IDX = tma_pkg::CFG_CAP_IDX + 2'd1;
  localparam logic [tma_pkg::CFG_IDX_W-1:0] CFG_SPARE_B_IDX = '1;

  localparam int MIN_MEAN_COUNT = 3;
  localparam int TRIMMED_SAMPLES = 2;
  localparam int RANDOM_ITEMS = 800;
  localparam int CLAMP_ADDS = 20;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [tma_pkg::VAL_W-1:0] value;
    logic [tma_pkg::ST_W-1:0]  status;
  } answer_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [tma_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tma_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           push = 1'b0;
  logic                           full;
  logic [tma_pkg::CMD_W-1:0]      command = tma_pkg::CMD_ADD;
  logic [tma_pkg::VAL_W-1:0]      sample = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic [tma_pkg::VAL_W-1:0]      value;
  logic [tma_pkg::ST_W-1:0]       status;

  // accumulator state as the block should hold it
  logic [1:0]                acc_width = WIDTH_8;
  logic [tma_pkg::CNT_W-1:0] acc_cap = tma_pkg::CAP_RESET;
  logic [tma_pkg::CNT_W-1:0] acc_count = '0;
  logic [tma_pkg::VAL_W-1:0] acc_sum = '0;
  logic [tma_pkg::VAL_W-1:0] acc_min = '1;
  logic [tma_pkg::VAL_W-1:0] acc_max = '0;

  answer_t expected_answers[$];
  int      mismatch_count = 0;
  bit      idle_on = 1'b1;
  int      pop_wait = 0;

  trimmed_mean_accumulator_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .command(command),
    .sample(sample),
    .empty(empty),
    .pop(pop),
    .value(value),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [tma_pkg::VAL_W-1:0] sample_mask(input logic [1:0] code);
    if (code == WIDTH_64) return '1;
    return (64'd1 << (8 << code)) - 64'd1;
  endfunction

  function automatic void reset_stats();
    acc_count = '0;
    acc_sum = '0;
    acc_min = '1;
    acc_max = '0;
  endfunction

  function automatic answer_t apply_command(input logic [tma_pkg::CMD_W-1:0] cmd,
                                            input logic [tma_pkg::VAL_W-1:0] smp);
    answer_t                    a;
    logic [tma_pkg::VAL_W-1:0]  s;
    longint unsigned            limit;
    a.value = '0;
    a.status = tma_pkg::ST_OK;
    limit = (acc_cap < tma_pkg::MAX_CAPACITY_DEF) ? acc_cap : tma_pkg::MAX_CAPACITY_DEF;
    case (cmd)
      tma_pkg::CMD_ADD: begin
        if (acc_count >= limit) begin
          a.status = tma_pkg::ST_FULL;
        end else begin
          s = smp & sample_mask(acc_width);
          acc_sum = acc_sum + s;
          if (s < acc_min) acc_min = s;
          if (s > acc_max) acc_max = s;
          acc_count = acc_count + 1'b1;
        end
      end
      tma_pkg::CMD_CLEAR: reset_stats();
      tma_pkg::CMD_MEAN: begin
        if (acc_count < MIN_MEAN_COUNT) begin
          a.status = tma_pkg::ST_TOO_FEW;
        end else begin
          a.value = (acc_sum - acc_min - acc_max) /
                    (64'(acc_count) - 64'(TRIMMED_SAMPLES));
        end
      end
      tma_pkg::CMD_SUM:   a.value = acc_sum;
      tma_pkg::CMD_COUNT: a.value = 64'(acc_count);
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [tma_pkg::VAL_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string field,
                                 input logic [tma_pkg::VAL_W-1:0] exp_v,
                                 input logic [tma_pkg::VAL_W-1:0] act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch %s: expected %h actual %h", field, exp_v, act_v);
  endtask

  // result side: random stalls while idle_on is set, check each beat against the oldest expectation
  always @(posedge clk) begin
    answer_t exp_a;
    int      nw;
    if (rst) begin
      pop <= 1'b0;
      pop_wait <= 0;
    end else if (pop && empty === 1'b0) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected beat", '0, value);
      end else begin
        exp_a = expected_answers.pop_front();
        if (value !== exp_a.value) report_mismatch("value", exp_a.value, value);
        if (status !== exp_a.status)
          report_mismatch("status", 64'(exp_a.status), 64'(status));
      end
      nw = idle_on ? $urandom_range(0, 3) : 0;
      pop_wait <= nw;
      pop <= (nw == 0);
    end else if (pop_wait != 0) begin
      pop_wait <= pop_wait - 1;
      pop <= (pop_wait == 1);
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send_item(input logic [tma_pkg::CMD_W-1:0] cmd,
                           input logic [tma_pkg::VAL_W-1:0] smp);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    command <= cmd;
    sample <= smp;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    expected_answers.push_back(apply_command(cmd, smp));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tma_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tma_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      tma_pkg::CFG_WIDTH_IDX: acc_width = data[1:0];
      tma_pkg::CFG_CAP_IDX:   acc_cap = data;
      default: ;
    endcase
  endtask

  task automatic test_empty_queries();
    send_item(tma_pkg::CMD_MEAN, '0);
    send_item(tma_pkg::CMD_SUM, '1);
    send_item(tma_pkg::CMD_COUNT, '0);
    send_item(CMD_SPARE_LO, '1);
    send_item(CMD_SPARE_LO + 3'd1, '0);
    send_item(CMD_SPARE_HI, 64'h0123_4567_89AB_CDEF);
    send_item(tma_pkg::CMD_CLEAR, '1);
  endtask

  // reset width: upper sample bits dropped
  task automatic test_narrow_adds();
    send_item(tma_pkg::CMD_ADD, '1);
    send_item(tma_pkg::CMD_ADD, '0);
    send_item(tma_pkg::CMD_MEAN, '0);
    send_item(tma_pkg::CMD_ADD, 64'hDEAD_BEEF_0000_0080);
    send_item(tma_pkg::CMD_MEAN, '0);
    send_item(tma_pkg::CMD_SUM, '0);
    send_item(tma_pkg::CMD_COUNT, '0);
  endtask

  // 64-bit samples, sum and trimmed difference wrap
  task automatic test_wide_wrap();
    wait_drained();
    write_reg(tma_pkg::CFG_WIDTH_IDX, 17'(WIDTH_64));
    send_item(tma_pkg::CMD_CLEAR, '0);
    send_item(tma_pkg::CMD_ADD, '1);
    send_item(tma_pkg::CMD_ADD, '1);
    send_item(tma_pkg::CMD_ADD, '0);
    send_item(tma_pkg::CMD_ADD, 64'd1);
    send_item(tma_pkg::CMD_MEAN, '0);
    send_item(tma_pkg::CMD_SUM, '0);
  endtask

  task automatic test_capacity_edges();
    wait_drained();
    write_reg(tma_pkg::CFG_CAP_IDX, '0);
    send_item(tma_pkg::CMD_CLEAR, '0);
    send_item(tma_pkg::CMD_ADD, 64'd5);
    wait_drained();
    write_reg(tma_pkg::CFG_CAP_IDX, 17'd1);
    write_reg(CFG_SPARE_A_IDX, '1);
    write_reg(CFG_SPARE_B_IDX, '0);
    send_item(tma_pkg::CMD_ADD, 64'd7);
    send_item(tma_pkg::CMD_ADD, 64'd9);
    send_item(tma_pkg::CMD_COUNT, '0);
  endtask

  // capacity above the hard limit: adds keep being accepted
  task automatic test_capacity_clamp();
    wait_drained();
    idle_on = 1'b0;
    write_reg(tma_pkg::CFG_WIDTH_IDX, 17'(WIDTH_16));
    write_reg(tma_pkg::CFG_CAP_IDX, '1);
    send_item(tma_pkg::CMD_CLEAR, '0);
    repeat (CLAMP_ADDS) send_item(tma_pkg::CMD_ADD, {$urandom, $urandom});
    send_item(tma_pkg::CMD_MEAN, '0);
    send_item(tma_pkg::CMD_SUM, '0);
    send_item(tma_pkg::CMD_COUNT, '0);
    send_item(tma_pkg::CMD_CLEAR, '0);
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int                        sent;
    int                        phase;
    int                        burst;
    int                        pick;
    logic [tma_pkg::CNT_W-1:0] cap;
    logic [tma_pkg::CMD_W-1:0] cmd;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      write_reg(tma_pkg::CFG_WIDTH_IDX, {15'($urandom), 2'(phase)});
      case (phase)
        0: cap = 17'd1;
        1: cap = 17'(tma_pkg::MAX_CAPACITY_DEF);
        2: cap = '0;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0) cap = '0;
          else if (pick == 1) cap = 17'($urandom_range(65537, 131071));
          else cap = 17'($urandom_range(2, 40));
        end
      endcase
      write_reg(tma_pkg::CFG_CAP_IDX, cap);
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A_IDX : CFG_SPARE_B_IDX, 17'($urandom));
      idle_on = (phase % 4 != 3);
      burst = $urandom_range(60, 140);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        if (phase == 1 && i == burst / 2) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 60) cmd = tma_pkg::CMD_ADD;
        else if (pick < 70) cmd = tma_pkg::CMD_MEAN;
        else if (pick < 78) cmd = tma_pkg::CMD_SUM;
        else if (pick < 86) cmd = tma_pkg::CMD_COUNT;
        else if (pick < 93) cmd = tma_pkg::CMD_CLEAR;
        else cmd = tma_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        send_item(cmd, random_sample());
        sent++;
      end
      phase++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_queries();
    test_narrow_adds();
    test_wide_wrap();
    test_capacity_edges();
    test_capacity_clamp();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    mismatch_count += expected_answers.size();
    if (mismatch_count == 0) begin
      $display("tb_trimmed_mean_accumulator_top OK");
    end else begin
      $display("tb_trimmed_mean_accumulator_top NOT OK");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb_trimmed_mean_accumulator_top NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/tma_pkg.sv
src/tma_fifo.sv
src/tma_front.sv
src/tma_back.sv
src/trimmed_mean_accumulator_top.sv
tb/tb_trimmed_mean_accumulator_top.sv
